// File: rtl/rgbxf_pkg.sv
// Package for the RGB cross-fade engine: shared widths, operation codes and
// the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package rgbxf_pkg;

    localparam int LEVEL_W  = 8;
    localparam int LEN_IN_W = 10;
    localparam int CHAN_N   = 3;
    localparam int CHAN_W   = 2;
    localparam int QUOT_W   = 8;
    localparam int BIT_W    = $clog2(QUOT_W);

    typedef logic [1:0] op_t;

    localparam op_t OP_START = 2'd0;
    localparam op_t OP_TICK  = 2'd1;
    localparam op_t OP_SET   = 2'd2;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [CHAN_N-1:0][LEVEL_W-1:0] rgb_t;

    typedef struct packed {
        logic              latch;
        logic              mul;
        logic              div;
        logic              wb;
        logic              emit;
        logic [CHAN_W-1:0] chan;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic run;
        logic out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/rgbxf_ctrl.sv
// Controller state machine of the RGB cross-fade engine.
// Depends on rgbxf_pkg; drives the datapath by command and reads its status.
`default_nettype none

module rgbxf_ctrl
    import rgbxf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_stall,
    input  dp_stat_t      stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_DIV,
        ST_WB,
        ST_EMIT
    } state_t;

    localparam logic [CHAN_W-1:0] CHAN_LAST = CHAN_W'(CHAN_N - 1);
    localparam logic [BIT_W-1:0]  BIT_TOP   = BIT_W'(QUOT_W - 1);

    state_t            state_reg, state_next;
    logic [CHAN_W-1:0] chan_reg, chan_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;

    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        bit_next   = bit_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                chan_next = '0;
                if (stat.op == OP_TICK && stat.run)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_MUL:
            begin
                bit_next   = BIT_TOP;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (bit_reg == '0)
                begin
                    state_next = ST_WB;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            ST_WB:
            begin
                if (chan_reg == CHAN_LAST)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    chan_next  = chan_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chan_reg  <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            bit_reg   <= bit_next;
        end
    end

    always_comb
    begin
        item_stall = (state_reg != ST_IDLE);
        cmd.latch  = (state_reg == ST_IDLE) && item_valid;
        cmd.mul    = (state_reg == ST_MUL);
        cmd.div    = (state_reg == ST_DIV);
        cmd.wb     = (state_reg == ST_WB);
        cmd.emit   = (state_reg == ST_EMIT) && !stat.out_busy;
        cmd.chan   = chan_reg;
    end

endmodule

`default_nettype wire

// File: rtl/rgbxf_datapath.sv
// Datapath of the RGB cross-fade engine: level stores, fade state, multiplier,
// shared restoring divider and output register.
// Depends on rgbxf_pkg; sequenced by rgbxf_ctrl.
`default_nettype none

module rgbxf_datapath
    import rgbxf_pkg::*;
#(
    parameter int STEP_BITS = 10,
    parameter int LEVEL_MAX = 255
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 stat,
    input  wire logic [1:0]          op,
    input  wire logic                group,
    input  wire logic [LEVEL_W-1:0]  red,
    input  wire logic [LEVEL_W-1:0]  green,
    input  wire logic [LEVEL_W-1:0]  blue,
    input  wire logic [LEN_IN_W-1:0] fade_length,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output logic                     pwm_write,
    output logic                     pwm_group,
    output logic [LEVEL_W-1:0]       duty_red,
    output logic [LEVEL_W-1:0]       duty_green,
    output logic [LEVEL_W-1:0]       duty_blue,
    output logic                     fade_done
);

    localparam int NUM_W     = STEP_BITS + 10;
    localparam int PROD_W    = LEVEL_W + STEP_BITS;
    localparam int LVL_CAP_I = (LEVEL_MAX > 255) ? 255 : LEVEL_MAX;
    localparam level_t LVL_CAP = LEVEL_W'(LVL_CAP_I);
    localparam level_t LVL_INV = LEVEL_W'(LEVEL_MAX % 256);

    // Latched input item.
    op_t                  op_in_reg;
    logic                 grp_in_reg;
    rgb_t                 lv_in_reg, lv_in_next;
    logic [STEP_BITS-1:0] len_in_reg;
    logic [STEP_BITS+LEN_IN_W-1:0] len_ext;

    // Architectural fade state.
    rgb_t                 cur_reg   [2];
    rgb_t                 start_reg [2];
    rgb_t                 tgt_reg   [2];
    logic [STEP_BITS-1:0] step_reg;
    logic [STEP_BITS-1:0] len_reg;
    logic                 fgrp_reg;
    logic                 run_reg;

    // Per-channel working registers.
    logic [NUM_W-1:0]     rem_reg;
    logic [NUM_W-1:0]     dsh_reg;
    logic [QUOT_W-1:0]    quo_reg;
    level_t               from_reg;
    level_t               to_reg;
    logic                 up_reg;

    // Output register.
    logic                 out_valid_reg;
    logic                 write_reg;
    logic                 ogrp_reg;
    rgb_t                 duty_reg;
    logic                 done_reg;

    level_t               from_sel, to_sel, diff;
    logic                 up;
    logic [PROD_W-1:0]    prod;
    logic [NUM_W-1:0]     num_init, dsh_init;
    logic                 ge;
    level_t               res;
    logic [STEP_BITS-1:0] step_inc;
    logic                 tick_run;
    logic                 emit_write;
    logic                 emit_grp;
    rgb_t                 emit_lvl;
    rgb_t                 emit_duty;
    logic                 emit_done;

    function automatic level_t clamp_level(input level_t v);
        return (v > LVL_CAP) ? LVL_CAP : v;
    endfunction

    always_comb
    begin
        lv_in_next[0] = clamp_level(red);
        lv_in_next[1] = clamp_level(green);
        lv_in_next[2] = clamp_level(blue);
        len_ext       = (STEP_BITS + LEN_IN_W)'(fade_length);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_in_reg  <= op;
            grp_in_reg <= group;
            lv_in_reg  <= lv_in_next;
            len_in_reg <= len_ext[STEP_BITS-1:0];
        end
    end

    // Multiply the level difference by the step and set up the divider.
    always_comb
    begin
        from_sel = start_reg[fgrp_reg][cmd.chan];
        to_sel   = tgt_reg[fgrp_reg][cmd.chan];
        up       = (to_sel >= from_sel);
        diff     = up ? (to_sel - from_sel) : (from_sel - to_sel);
        prod     = PROD_W'(diff) * PROD_W'(step_reg);
        num_init = NUM_W'({prod, 1'b0}) + NUM_W'(len_reg);
        dsh_init = NUM_W'(len_reg) << QUOT_W;
        ge       = (rem_reg >= dsh_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            rem_reg  <= num_init;
            dsh_reg  <= dsh_init;
            quo_reg  <= '0;
            from_reg <= from_sel;
            to_reg   <= to_sel;
            up_reg   <= up;
        end
        else if (cmd.div)
        begin
            rem_reg <= ge ? (rem_reg - dsh_reg) : rem_reg;
            quo_reg <= {quo_reg[QUOT_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // The rounded offset never exceeds the difference, so no clamp is needed.
    always_comb
    begin
        if (len_reg == '0)
        begin
            res = to_reg;
        end
        else if (up_reg)
        begin
            res = from_reg + quo_reg;
        end
        else if (quo_reg >= from_reg)
        begin
            res = '0;
        end
        else
        begin
            res = from_reg - quo_reg;
        end
    end

    // Result of the item and the fade-done flag after its state update.
    always_comb
    begin
        step_inc   = step_reg + 1'b1;
        tick_run   = (op_in_reg == OP_TICK) && run_reg;
        emit_write = tick_run || (op_in_reg == OP_SET);
        emit_grp   = tick_run ? fgrp_reg : grp_in_reg;
        emit_lvl   = tick_run ? cur_reg[fgrp_reg] : lv_in_reg;
        for (int c = 0; c < CHAN_N; c++)
        begin
            if (!emit_write)
            begin
                emit_duty[c] = '0;
            end
            else if (emit_grp)
            begin
                emit_duty[c] = LVL_INV - emit_lvl[c];
            end
            else
            begin
                emit_duty[c] = emit_lvl[c];
            end
        end
        priority if (op_in_reg == OP_START)
        begin
            emit_done = (len_in_reg == '0);
        end
        else if (tick_run && (step_reg < len_reg))
        begin
            emit_done = (step_inc == len_reg);
        end
        else
        begin
            emit_done = (step_reg == len_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < 2; g++)
            begin
                cur_reg[g]   <= '0;
                start_reg[g] <= '0;
                tgt_reg[g]   <= '0;
            end
            step_reg <= '0;
            len_reg  <= '0;
            fgrp_reg <= 1'b0;
            run_reg  <= 1'b0;
        end
        else if (cmd.wb)
        begin
            cur_reg[fgrp_reg][cmd.chan] <= res;
        end
        else if (cmd.emit)
        begin
            unique case (op_in_reg)
                OP_START:
                begin
                    tgt_reg[grp_in_reg]   <= lv_in_reg;
                    start_reg[grp_in_reg] <= cur_reg[grp_in_reg];
                    len_reg               <= len_in_reg;
                    fgrp_reg              <= grp_in_reg;
                    step_reg              <= '0;
                    run_reg               <= 1'b1;
                end
                OP_TICK:
                begin
                    if (run_reg)
                    begin
                        if (step_reg < len_reg)
                        begin
                            step_reg <= step_inc;
                        end
                        else
                        begin
                            run_reg             <= 1'b0;
                            start_reg[fgrp_reg] <= tgt_reg[fgrp_reg];
                        end
                    end
                end
                OP_SET:
                begin
                    cur_reg[grp_in_reg] <= lv_in_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            write_reg <= emit_write;
            ogrp_reg  <= emit_write ? emit_grp : 1'b0;
            duty_reg  <= emit_duty;
            done_reg  <= emit_done;
        end
    end

    always_comb
    begin
        stat.op       = op_in_reg;
        stat.run      = run_reg;
        stat.out_busy = out_valid_reg && result_stall;
        result_valid  = out_valid_reg;
        pwm_write     = write_reg;
        pwm_group     = ogrp_reg;
        duty_red      = duty_reg[0];
        duty_green    = duty_reg[1];
        duty_blue     = duty_reg[2];
        fade_done     = done_reg;
    end

endmodule

`default_nettype wire

// File: rtl/rgb_crossfade_engine.sv
// Top level of the RGB cross-fade engine: controller plus datapath.
// Depends on rgbxf_pkg, rgbxf_ctrl and rgbxf_datapath.
//
//   Channel  Handshake                    Payload
//   -------  ---------------------------  -------------------------------------
//   item     item_valid / item_stall      op, group, red, green, blue,
//                                         fade_length
//   result   result_valid / result_stall  pwm_write, pwm_group, duty_red,
//                                         duty_green, duty_blue, fade_done
//
// One item is worked on at a time and every item yields exactly one result.
// A tick during a running fade passes through the transfer, a decode state,
// then for each of the three channels a multiply state, eight steps of the
// shared restoring divider and a write-back state, then loads the result register.
// Start, set, idle ticks and the unused code go from decode straight to the load.
// Reset is asynchronous and clears all levels and the fade state to zero.
// The result register stays loaded while result_stall is high; the next item is
// still taken and worked on, and waits in its last state until the register
// is free.
`default_nettype none

module rgb_crossfade_engine
    import rgbxf_pkg::*;
#(
    parameter int STEP_BITS = 10,
    parameter int LEVEL_MAX = 255
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire logic [1:0]          op,
    input  wire logic                group,
    input  wire logic [LEVEL_W-1:0]  red,
    input  wire logic [LEVEL_W-1:0]  green,
    input  wire logic [LEVEL_W-1:0]  blue,
    input  wire logic [LEN_IN_W-1:0] fade_length,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output logic                     pwm_write,
    output logic                     pwm_group,
    output logic [LEVEL_W-1:0]       duty_red,
    output logic [LEVEL_W-1:0]       duty_green,
    output logic [LEVEL_W-1:0]       duty_blue,
    output logic                     fade_done
);

    // Commands flow from the controller to the datapath, status flows back.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    rgbxf_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    // The datapath holds all levels, the step counter and the result register.
    rgbxf_datapath #(
        .STEP_BITS (STEP_BITS),
        .LEVEL_MAX (LEVEL_MAX)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .op           (op),
        .group        (group),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .fade_length  (fade_length),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pwm_write    (pwm_write),
        .pwm_group    (pwm_group),
        .duty_red     (duty_red),
        .duty_green   (duty_green),
        .duty_blue    (duty_blue),
        .fade_done    (fade_done)
    );

endmodule

`default_nettype wire

// File: rtl/rgbxf_checker.sv
// Port-level assertions for the RGB cross-fade engine and their bind.
// Depends on rgbxf_pkg and the rgb_crossfade_engine port list.
`default_nettype none

module rgbxf_checker
    import rgbxf_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               item_valid,
    input wire logic               item_stall,
    input wire logic               result_valid,
    input wire logic               result_stall,
    input wire logic               pwm_write,
    input wire logic               pwm_group,
    input wire logic [LEVEL_W-1:0] duty_red,
    input wire logic [LEVEL_W-1:0] duty_green,
    input wire logic [LEVEL_W-1:0] duty_blue,
    input wire logic               fade_done
);

    // An accepted item keeps the engine busy for at least the next cycle.
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("item channel free right after a transfer");

    // A new result only appears while an item was being worked on.
    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result appeared with no item in progress");

    // A stalled result stays valid and unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(pwm_write)
            && $stable(pwm_group) && $stable(duty_red) && $stable(duty_green)
            && $stable(duty_blue) && $stable(fade_done))
        else $error("stalled result changed");

    // A result that writes no duty carries zero duties and the outer group.
    a_idle_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !pwm_write |-> !pwm_group && duty_red == '0
            && duty_green == '0 && duty_blue == '0)
        else $error("non-write result carries duty values");

endmodule

bind rgb_crossfade_engine rgbxf_checker u_rgbxf_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pwm_write    (pwm_write),
    .pwm_group    (pwm_group),
    .duty_red     (duty_red),
    .duty_green   (duty_green),
    .duty_blue    (duty_blue),
    .fade_done    (fade_done)
);

`default_nettype wire

// File: verif/tb_rgb_crossfade_engine.sv
`timescale 1ns / 100ps
// Testbench for rgb_crossfade_engine: directed and random start, tick, set and unused-code
// transfers with random idling on both sides, checked against a cycle-free fade predictor.
// Depends on rgbxf_pkg and the rgb_crossfade_engine RTL.

module tb_rgb_crossfade_engine;
    import rgbxf_pkg::*;

    localparam int  STEP_W       = 10;
    localparam int  FULL_LEVEL   = 255;
    localparam int  RANDOM_ITEMS = 1500;
    localparam op_t OP_UNUSED    = 2'd3;

    typedef struct packed {
        op_t                 op;
        logic                grp;
        level_t              r;
        level_t              g;
        level_t              b;
        logic [LEN_IN_W-1:0] len;
    } fade_cmd_t;

    typedef struct packed {
        logic   write;
        logic   grp;
        level_t r;
        level_t g;
        level_t b;
        logic   done;
    } duty_word_t;

    // One channel of the linear fade: src + round_half_away((dst - src) * pos / span).
    function automatic level_t blend(level_t src, level_t dst, int unsigned pos,
                                     int unsigned span);
        longint unsigned s;
        longint unsigned d;
        longint unsigned mag;
        longint unsigned quo;
        s = src;
        d = dst;
        if (span == 0)
            return dst;
        if (d >= s)
        begin
            mag = (d - s) * pos;
            quo = (2 * mag + span) / (2 * span);
            return (s + quo > FULL_LEVEL) ? level_t'(FULL_LEVEL) : level_t'(s + quo);
        end
        mag = (s - d) * pos;
        quo = (2 * mag + span) / (2 * span);
        return (quo >= s) ? level_t'(0) : level_t'(s - quo);
    endfunction

    // Tracks the level and fade state of both groups and holds the duty words
    // still owed by the block, oldest first.
    class fade_scoreboard;
        level_t            lvl_now[6];
        level_t            lvl_src[6];
        level_t            lvl_dst[6];
        logic [STEP_W-1:0] pos;
        logic [STEP_W-1:0] span;
        logic              fade_grp;
        logic              fading;
        duty_word_t        duty_q[$];
        int                mismatches;

        function new();
            foreach (lvl_now[i])
            begin
                lvl_now[i] = '0;
                lvl_src[i] = '0;
                lvl_dst[i] = '0;
            end
            pos        = '0;
            span       = '0;
            fade_grp   = 1'b0;
            fading     = 1'b0;
            mismatches = 0;
        endfunction

        function void load_duty(ref duty_word_t w, input logic grp);
            int     base;
            level_t v[3];
            base = grp ? 3 : 0;
            for (int c = 0; c < 3; c++)
            begin
                v[c] = lvl_now[base + c];
                // The inner group is wired active low.
                if (grp)
                    v[c] = level_t'(FULL_LEVEL) - v[c];
            end
            w.write = 1'b1;
            w.grp   = grp;
            w.r     = v[0];
            w.g     = v[1];
            w.b     = v[2];
        endfunction

        function void note_item(fade_cmd_t cmd);
            duty_word_t w;
            level_t     lv[3];
            int         base;
            w     = '0;
            lv[0] = cmd.r;
            lv[1] = cmd.g;
            lv[2] = cmd.b;
            base  = cmd.grp ? 3 : 0;
            case (cmd.op)
                OP_START:
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        lvl_dst[base + c] = lv[c];
                        lvl_src[base + c] = lvl_now[base + c];
                    end
                    span     = STEP_W'(cmd.len);
                    fade_grp = cmd.grp;
                    pos      = '0;
                    fading   = 1'b1;
                end
                OP_TICK:
                begin
                    if (fading)
                    begin
                        base = fade_grp ? 3 : 0;
                        for (int c = 0; c < 3; c++)
                            lvl_now[base + c] = blend(lvl_src[base + c], lvl_dst[base + c],
                                                      pos, span);
                        load_duty(w, fade_grp);
                        if (pos < span)
                            pos = pos + 1'b1;
                        else
                        begin
                            fading = 1'b0;
                            for (int c = 0; c < 3; c++)
                                lvl_src[base + c] = lvl_dst[base + c];
                        end
                    end
                end
                OP_SET:
                begin
                    for (int c = 0; c < 3; c++)
                        lvl_now[base + c] = lv[c];
                    load_duty(w, cmd.grp);
                end
                default: ;
            endcase
            w.done = (pos == span);
            duty_q.push_back(w);
        endfunction

        function void flag(string why, duty_word_t want, duty_word_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: duty mismatch (%s): expected write=%0d grp=%0d rgb=%0d/%0d/%0d",
                         $time, why, want.write, want.grp, want.r, want.g, want.b,
                         " done=%0d, got write=%0d grp=%0d rgb=%0d/%0d/%0d done=%0d",
                         want.done, got.write, got.grp, got.r, got.g, got.b, got.done);
        endfunction

        function void check_result(duty_word_t got);
            duty_word_t want;
            string      bad;
            bad = "";
            if (duty_q.size() == 0)
            begin
                flag("no item outstanding", '0, got);
                return;
            end
            want = duty_q.pop_front();
            if (got.write !== want.write)
                bad = {bad, " pwm_write"};
            if (got.grp !== want.grp)
                bad = {bad, " pwm_group"};
            if (got.r !== want.r)
                bad = {bad, " duty_red"};
            if (got.g !== want.g)
                bad = {bad, " duty_green"};
            if (got.b !== want.b)
                bad = {bad, " duty_blue"};
            if (got.done !== want.done)
                bad = {bad, " fade_done"};
            if (bad != "")
                flag(bad, want, got);
        endfunction

        function int pending();
            return duty_q.size();
        endfunction
    endclass

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_stall;
    logic [1:0]          op           = OP_TICK;
    logic                group        = 1'b0;
    logic [LEVEL_W-1:0]  red          = '0;
    logic [LEVEL_W-1:0]  green        = '0;
    logic [LEVEL_W-1:0]  blue         = '0;
    logic [LEN_IN_W-1:0] fade_length  = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic                pwm_write;
    logic                pwm_group;
    logic [LEVEL_W-1:0]  duty_red;
    logic [LEVEL_W-1:0]  duty_green;
    logic [LEVEL_W-1:0]  duty_blue;
    logic                fade_done;

    fade_scoreboard ledger;
    bit             quiet;
    int             useful;

    rgb_crossfade_engine dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .op           (op),
        .group        (group),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .fade_length  (fade_length),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pwm_write    (pwm_write),
        .pwm_group    (pwm_group),
        .duty_red     (duty_red),
        .duty_green   (duty_green),
        .duty_blue    (duty_blue),
        .fade_done    (fade_done)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Both sides share the quiet flag, so some stretches run back to back.
    function automatic int idle_draw();
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic fade_cmd_t cmd_of(op_t o, logic grp, level_t r, level_t g, level_t b,
                                         int len);
        fade_cmd_t c;
        c.op  = o;
        c.grp = grp;
        c.r   = r;
        c.g   = g;
        c.b   = b;
        c.len = LEN_IN_W'(len);
        return c;
    endfunction

    function automatic fade_cmd_t rand_cmd(op_t o);
        return cmd_of(o, 1'($urandom_range(0, 1)), level_t'($urandom_range(0, 255)),
                      level_t'($urandom_range(0, 255)), level_t'($urandom_range(0, 255)),
                      int'($urandom_range(0, 1023)));
    endfunction

    // Valid stays high into the next transfer when no gap is drawn, so it is
    // only ever lowered here or in drain().
    task automatic send(fade_cmd_t cmd);
        int gap;
        gap = idle_draw();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        op          <= cmd.op;
        group       <= cmd.grp;
        red         <= cmd.r;
        green       <= cmd.g;
        blue        <= cmd.b;
        fade_length <= cmd.len;
        do
            @(posedge clk);
        while (item_stall);
        ledger.note_item(cmd);
        if (cmd.op != OP_UNUSED)
            useful++;
    endtask

    // Waits on the clock before it checks the ledger, so the next drive lands in a later time step.
    task automatic drain();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (ledger.pending() != 0);
    endtask

    task automatic tick();
        send(rand_cmd(OP_TICK));
    endtask

    initial
    begin : result_sink
        int         hold;
        duty_word_t got;
        @(posedge rst_n);
        forever
        begin
            hold = idle_draw();
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!result_valid);
            got.write = pwm_write;
            got.grp   = pwm_group;
            got.r     = duty_red;
            got.g     = duty_green;
            got.b     = duty_blue;
            got.done  = fade_done;
            ledger.check_result(got);
        end
    end

    initial
    begin
        #6_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        fade_cmd_t cmd;
        int        kind;
        int        ticks;
        ledger = new();
        quiet  = 1'b0;
        useful = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Tick with no fade running, then the unused code with every bit set.
        tick();
        send(cmd_of(OP_UNUSED, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1023));
        // Immediate sets at both extremes; the inner group comes out inverted.
        send(cmd_of(OP_SET, 1'b0, 8'hFF, 8'hFF, 8'hFF, 0));
        send(cmd_of(OP_SET, 1'b1, 8'h00, 8'h00, 8'h00, 1023));
        send(cmd_of(OP_SET, 1'b1, 8'hFF, 8'h80, 8'h01, 0));
        // A zero-length fade jumps straight to the target on its first tick.
        send(cmd_of(OP_START, 1'b0, 8'h00, 8'h00, 8'h00, 0));
        tick();
        tick();
        // Short fade upward with rounding on the third steps.
        send(cmd_of(OP_START, 1'b0, 8'hFF, 8'h00, 8'hAA, 3));
        repeat (4) tick();
        // Fade downward on red and blue where the midpoint lands on a half and rounds away from zero.
        send(cmd_of(OP_START, 1'b0, 8'h00, 8'hFF, 8'h55, 2));
        repeat (3) tick();
        // Longest fade on the inner group, overwritten by a set while it runs.
        send(cmd_of(OP_START, 1'b1, 8'hAA, 8'h55, 8'hFF, 1023));
        tick();
        tick();
        send(cmd_of(OP_SET, 1'b1, 8'd10, 8'd20, 8'd30, 0));
        tick();

        // Hold the sender until the block has answered everything.
        drain();

        while (useful < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
                quiet = !quiet;
            if ($urandom_range(0, 39) == 0)
                drain();
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                // A whole fade: mostly short lengths so they run to the end,
                // now and then a long one that gets cut off by the next start.
                cmd = rand_cmd(OP_START);
                if ($urandom_range(0, 19) != 0)
                    cmd.len = LEN_IN_W'($urandom_range(0, 12));
                send(cmd);
                ticks = (cmd.len <= 12) ? cmd.len + 1 : $urandom_range(1, 40);
                case ($urandom_range(0, 5))
                    0: ticks = $urandom_range(0, ticks);
                    1: ticks = ticks + $urandom_range(1, 3);
                    default: ;
                endcase
                repeat (ticks)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send(rand_cmd(OP_SET));
                    tick();
                end
            end
            else if (kind <= 7)
                send(rand_cmd(OP_SET));
            else
                send(rand_cmd(op_t'($urandom_range(0, 3))));
        end

        drain();
        repeat (40) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
